// ===== sv/hot_page_promotion_policy_macros.svh =====
// Assertion macros shared by the hot page promotion policy RTL.
`ifndef HOT_PAGE_PROMOTION_POLICY_MACROS_SVH
`define HOT_PAGE_PROMOTION_POLICY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HPP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hot page policy check failed");

// Next-cycle implication, checked outside reset.
`define HPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hot page policy check failed");

`endif

// ===== sv/hpp_pkg.sv =====
// Types and constants shared by the hot page promotion policy modules.
`default_nettype none
package hpp_pkg;

  localparam int NUM_SLOTS     = 8192;
  localparam int SLOT_IDX_W    = $clog2(NUM_SLOTS);
  localparam int PAGE_W        = 13;
  localparam int RUN_W         = 8;
  localparam int HOT_COUNT_W   = 14;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TRACKING_ENABLE    = 2'd0,
    REG_PROMOTE_THRESHOLD  = 2'd1,
    REG_COOLDOWN_THRESHOLD = 2'd2
  } hpp_reg_t;

  typedef logic [SLOT_IDX_W-1:0] hpp_idx_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_slot;
    logic [PAGE_W-1:0] ram_page;
    logic              was_dirty;
  } hpp_in_t;

  typedef struct packed {
    logic [PAGE_W-1:0]      page_slot_out;
    logic                   is_hot;
    logic                   promoted;
    logic                   reprotect;
    logic [PAGE_W-1:0]      reprotect_page;
    logic [HOT_COUNT_W-1:0] hot_count;
  } hpp_out_t;

  typedef struct packed {
    logic [RUN_W-1:0] dirty_run;
    logic [RUN_W-1:0] clean_run;
    logic             hot;
  } hpp_entry_t;

  typedef struct packed {
    logic       en;
    hpp_idx_t   slot;
    hpp_entry_t entry;
  } hpp_wr_t;

  typedef struct packed {
    logic             enable;
    logic [RUN_W-1:0] promote;
    logic [RUN_W-1:0] cooldown;
  } hpp_cfg_t;

endpackage
`default_nettype wire

// ===== sv/hpp_page_store.sv =====
// Per-page record memory with post-reset clearing sweep and write-to-read bypass.
`default_nettype none
module hpp_page_store
  import hpp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rd_en,
  input  wire hpp_idx_t   rd_slot,
  input  wire hpp_wr_t    wr,
  output hpp_entry_t      rd_entry,
  output logic            clearing
);

  hpp_entry_t mem [NUM_SLOTS];
  hpp_entry_t rd_data;
  hpp_entry_t fwd_entry;
  logic       fwd_hit;
  hpp_idx_t   clr_addr;

  // After reset every record is swept to zero, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == SLOT_IDX_W'(NUM_SLOTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.slot] <= wr.entry;
    end
  end

  // A read that lands on the record being written in the same cycle
  // takes the new value from the bypass register instead of the array.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data   <= mem[rd_slot];
      fwd_hit   <= wr.en && (wr.slot == rd_slot);
      fwd_entry <= wr.entry;
    end
  end

  assign rd_entry = fwd_hit ? fwd_entry : rd_data;

endmodule
`default_nettype wire

// ===== sv/hpp_update.sv =====
// Promotion and cooldown decision for one page record.
`default_nettype none
module hpp_update
  import hpp_pkg::*;
(
  input  wire hpp_entry_t             entry,
  input  wire hpp_in_t                item,
  input  wire hpp_cfg_t               cfg,
  input  wire logic [HOT_COUNT_W-1:0] hot_total,
  output hpp_entry_t                  entry_next,
  output logic                        wr_en,
  output hpp_out_t                    result,
  output logic [HOT_COUNT_W-1:0]      hot_total_next
);

  function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  logic             in_range;
  logic [RUN_W-1:0] dirty_new;
  logic [RUN_W-1:0] clean_new;
  logic             hot;
  logic             promoted;
  logic             reprotect;

  assign in_range = 32'(item.page_slot) < NUM_SLOTS;
  assign wr_en    = in_range && cfg.enable;

  always_comb begin
    dirty_new      = item.was_dirty ? run_inc(entry.dirty_run) : '0;
    clean_new      = entry.clean_run;
    hot            = entry.hot;
    promoted       = 1'b0;
    reprotect      = 1'b0;
    hot_total_next = hot_total;
    if (cfg.enable) begin
      if (entry.hot) begin
        clean_new = item.was_dirty ? '0 : run_inc(entry.clean_run);
        if (clean_new >= cfg.cooldown) begin
          hot       = 1'b0;
          reprotect = 1'b1;
          if (hot_total != '0) begin
            hot_total_next = hot_total - 1'b1;
          end
        end
      end else if (dirty_new >= cfg.promote) begin
        hot            = 1'b1;
        clean_new      = '0;
        promoted       = 1'b1;
        hot_total_next = hot_total + 1'b1;
      end
    end
    if (!in_range) begin
      hot            = 1'b0;
      promoted       = 1'b0;
      reprotect      = 1'b0;
      hot_total_next = hot_total;
    end
  end

  assign entry_next.dirty_run = dirty_new;
  assign entry_next.clean_run = clean_new;
  assign entry_next.hot       = hot;

  assign result.page_slot_out  = item.page_slot;
  assign result.is_hot         = hot;
  assign result.promoted       = promoted;
  assign result.reprotect      = reprotect;
  assign result.reprotect_page = reprotect ? item.ram_page : '0;
  assign result.hot_count      = hot_total_next;

endmodule
`default_nettype wire

// ===== sv/hot_page_promotion_policy.sv =====
// Hot page promotion policy: top level with config registers and pipeline control.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_data  (hpp_in_t)
//   out     | output    | out_valid / out_ready| out_data (hpp_out_t)
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One page beat can be accepted per cycle while in_ready is high; its result is
// registered in the output register once the item stage advances.
// The record memory has one read and one write port, read at acceptance and
// written back as the item advances, with a bypass for the same page back to back.
// After reset a clearing sweep runs over all NUM_SLOTS (8192) records with
// in_ready low; configuration writes are taken throughout.
// A stalled output holds the result register and the stage behind it.
`default_nettype none
`include "hot_page_promotion_policy_macros.svh"
module hot_page_promotion_policy
  import hpp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire hpp_in_t                in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output hpp_out_t                    out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  hpp_cfg_t               cfg;
  hpp_in_t                s1_item;
  logic                   s1_valid;
  logic                   advance;
  logic                   s1_go;
  logic                   accept;
  logic                   clearing;
  hpp_entry_t             rd_entry;
  hpp_entry_t             entry_next;
  logic                   upd_wr_en;
  hpp_out_t               result;
  logic [HOT_COUNT_W-1:0] hot_total;
  logic [HOT_COUNT_W-1:0] hot_total_next;
  hpp_wr_t                wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable   <= 1'b0;
      cfg.promote  <= RUN_W'(4);
      cfg.cooldown <= RUN_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRACKING_ENABLE:    cfg.enable   <= cfg_data[0];
        REG_PROMOTE_THRESHOLD:  cfg.promote  <= cfg_data[RUN_W-1:0];
        REG_COOLDOWN_THRESHOLD: cfg.cooldown <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid || out_ready;
  assign s1_go    = s1_valid && advance;
  assign in_ready = !clearing && (!s1_valid || advance);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      hot_total <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
        hot_total <= hot_total_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_data;
    end
    if (s1_go) begin
      out_data <= result;
    end
  end

  assign wr.en    = s1_go && upd_wr_en;
  assign wr.slot  = s1_item.page_slot[SLOT_IDX_W-1:0];
  assign wr.entry = entry_next;

  hpp_page_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_slot  (in_data.page_slot[SLOT_IDX_W-1:0]),
    .wr       (wr),
    .rd_entry (rd_entry),
    .clearing (clearing)
  );

  hpp_update u_update (
    .entry          (rd_entry),
    .item           (s1_item),
    .cfg            (cfg),
    .hot_total      (hot_total),
    .entry_next     (entry_next),
    .wr_en          (upd_wr_en),
    .result         (result),
    .hot_total_next (hot_total_next)
  );

  `HPP_ASSERT_IMP(a_no_accept_while_clearing, clk, rst, clearing, !in_ready)
  `HPP_ASSERT_IMP(a_hot_total_bounded, clk, rst, 1'b1, 32'(hot_total) <= NUM_SLOTS)
  `HPP_ASSERT_IMP(a_reprotect_leaves_cold, clk, rst, out_valid && out_data.reprotect,
                  !out_data.is_hot && !out_data.promoted)
  `HPP_ASSERT_IMP(a_promote_is_hot, clk, rst, out_valid && out_data.promoted, out_data.is_hot)
  `HPP_ASSERT_NEXT(a_count_tracks_result, clk, rst, s1_go, out_data.hot_count == hot_total)

endmodule
`default_nettype wire

// ===== test/hot_page_promotion_policy_tb.sv =====
// Self-checking testbench for the hot page promotion policy block.
module hot_page_promotion_policy_tb;
  import hpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 200;
  localparam int POOL_N      = 6;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  hpp_in_t                in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  hpp_out_t               out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  hot_page_promotion_policy u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  typedef struct {
    bit       known;
    hpp_out_t want;
  } page_note_t;

  typedef struct {
    bit         is_cfg;
    hpp_reg_t   reg_sel;
    logic [7:0] reg_val;
    hpp_in_t    beat;
    bit         known;
    hpp_out_t   want;
  } plan_row_t;

  // Shadow of the per-page records and registers.
  bit [RUN_W-1:0] dirty_run [NUM_SLOTS];
  bit [RUN_W-1:0] clean_run [NUM_SLOTS];
  bit             hot_mark  [NUM_SLOTS];
  int             hot_total  = 0;
  bit             trk_en     = 1'b0;
  bit [RUN_W-1:0] promo_thr  = 8'd4;
  bit [RUN_W-1:0] cool_thr   = 8'd8;

  page_note_t  note_q[$];
  hpp_out_t    page_result_q[$];
  plan_row_t   plan_q[$];
  int unsigned slot_pool[POOL_N];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holds_asked    = 0;
  int holds_served   = 0;
  int fault_count    = 0;
  int n_beats        = 0;
  int n_results      = 0;
  int n_promoted     = 0;
  int n_reprotect    = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results still expected", page_result_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic hpp_out_t track_page(input hpp_in_t beat);
    hpp_out_t    res;
    int unsigned s;
    bit          hot;
    res = '0;
    s = beat.page_slot;
    res.page_slot_out = beat.page_slot;
    if (s < NUM_SLOTS) begin
      hot = hot_mark[s];
      if (trk_en) begin
        dirty_run[s] = beat.was_dirty ? sat_inc(dirty_run[s]) : '0;
        if (hot) begin
          clean_run[s] = beat.was_dirty ? '0 : sat_inc(clean_run[s]);
          if (clean_run[s] >= cool_thr) begin
            hot_mark[s] = 1'b0;
            hot = 1'b0;
            res.reprotect = 1'b1;
            res.reprotect_page = beat.ram_page;
            if (hot_total > 0) hot_total--;
          end
        end else if (dirty_run[s] >= promo_thr) begin
          hot_mark[s] = 1'b1;
          hot = 1'b1;
          clean_run[s] = '0;
          res.promoted = 1'b1;
          hot_total++;
        end
      end
      res.is_hot = hot;
    end
    res.hot_count = HOT_COUNT_W'(hot_total);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, got);
    if (got !== want) begin
      fault_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Input and output beats are both sampled on the same edge the block sees.
  always @(posedge clk) begin
    page_note_t note;
    hpp_out_t   pred;
    hpp_out_t   want;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TRACKING_ENABLE:    trk_en = cfg_data[0];
          REG_PROMOTE_THRESHOLD:  promo_thr = cfg_data;
          REG_COOLDOWN_THRESHOLD: cool_thr = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        note = note_q.pop_front();
        pred = track_page(in_data);
        n_beats++;
        n_promoted += pred.promoted;
        n_reprotect += pred.reprotect;
        page_result_q.insert(page_result_q.size(), note.known ? note.want : pred);
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (page_result_q.size() == 0) begin
          fault_count++;
          $display("%0t: result for slot %0d with none expected", $time,
                   out_data.page_slot_out);
        end else begin
          want = page_result_q.pop_front();
          check_field("page_slot_out", want.page_slot_out, out_data.page_slot_out);
          check_field("is_hot", want.is_hot, out_data.is_hot);
          check_field("promoted", want.promoted, out_data.promoted);
          check_field("reprotect", want.reprotect, out_data.reprotect);
          check_field("reprotect_page", want.reprotect_page, out_data.reprotect_page);
          check_field("hot_count", want.hot_count, out_data.hot_count);
        end
      end
    end
  end

  // Receiver: random back-pressure, plus long hold-offs on request.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_beat(input hpp_in_t beat, input bit known, input hpp_out_t want);
    page_note_t note;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    note.known = known;
    note.want = want;
    note_q.insert(note_q.size(), note);
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Leaves the block idle: every expected result back and the pipe flushed.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (note_q.size() != 0 || page_result_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input hpp_reg_t sel, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic plan_cfg(input hpp_reg_t sel, input logic [7:0] val);
    plan_row_t row;
    row = '{reg_sel: REG_TRACKING_ENABLE, default: '0};
    row.is_cfg = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    plan_q.insert(plan_q.size(), row);
  endtask

  task automatic plan_beat(input int slot, ram, input bit dirty, input bit known,
                           input hpp_out_t want);
    plan_row_t row;
    row = '{reg_sel: REG_TRACKING_ENABLE, default: '0};
    row.beat.page_slot = 13'(slot);
    row.beat.ram_page = 13'(ram);
    row.beat.was_dirty = dirty;
    row.known = known;
    row.want = want;
    plan_q.insert(plan_q.size(), row);
  endtask

  // Pages arrive as runs of same-dirtiness frames on a few slots, so that
  // thresholds are crossed; one run in five is a lone beat on any slot.
  task automatic run_phase(input bit en, input logic [7:0] promote, cooldown,
                           input int send_pct, recv_pct, n_items, pool_n,
                           run_lo, run_hi, input bit hold);
    int      sent;
    int      run_len;
    bit      noise;
    hpp_in_t beat;
    wait_drained();
    write_reg(REG_TRACKING_ENABLE, {7'($urandom_range(127)), en});
    write_reg(REG_PROMOTE_THRESHOLD, promote);
    write_reg(REG_COOLDOWN_THRESHOLD, cooldown);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) holds_asked++;
    sent = 0;
    while (sent < n_items) begin
      noise = ($urandom_range(4) == 0);
      beat.page_slot = noise ? 13'($urandom_range(8191))
                             : 13'(slot_pool[$urandom_range(pool_n - 1)]);
      beat.was_dirty = 1'($urandom_range(1));
      run_len = noise ? 1 : $urandom_range(run_hi, run_lo);
      repeat (run_len) if (sent < n_items) begin
        beat.ram_page = 13'($urandom_range(8191));
        send_beat(beat, 1'b0, '0);
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Tracking is off after reset, so nothing moves.
    plan_beat(0, 0, 1'b1, 1'b1, hpp_out_t'{13'd0, 1'b0, 1'b0, 1'b0, 13'd0, 14'd0});
    plan_beat(8191, 8191, 1'b0, 1'b1,
              hpp_out_t'{13'd8191, 1'b0, 1'b0, 1'b0, 13'd0, 14'd0});
    plan_cfg(REG_TRACKING_ENABLE, 8'd1);
    // A zero promote threshold promotes on clean and dirty frames alike.
    plan_cfg(REG_PROMOTE_THRESHOLD, 8'd0);
    plan_beat(8191, 8191, 1'b0, 1'b1,
              hpp_out_t'{13'd8191, 1'b1, 1'b1, 1'b0, 13'd0, 14'd1});
    plan_beat(0, 8191, 1'b1, 1'b1, hpp_out_t'{13'd0, 1'b1, 1'b1, 1'b0, 13'd0, 14'd2});
    // A zero cooldown threshold drops a hot page on its next update.
    plan_cfg(REG_COOLDOWN_THRESHOLD, 8'd0);
    plan_beat(8191, 1234, 1'b1, 1'b1,
              hpp_out_t'{13'd8191, 1'b0, 1'b0, 1'b1, 13'd1234, 14'd1});
    plan_beat(0, 0, 1'b0, 1'b1, hpp_out_t'{13'd0, 1'b0, 1'b0, 1'b1, 13'd0, 14'd0});
    plan_cfg(REG_PROMOTE_THRESHOLD, 8'd2);
    plan_cfg(REG_COOLDOWN_THRESHOLD, 8'd2);
    plan_beat(100, 13'h0AAA, 1'b1, 1'b0, '0);
    plan_beat(100, 13'h1555, 1'b1, 1'b0, '0);
    plan_beat(100, 13'h1555, 1'b0, 1'b0, '0);
    plan_beat(100, 13'h1555, 1'b1, 1'b0, '0);
    plan_beat(100, 13'h1555, 1'b0, 1'b0, '0);
    plan_beat(100, 13'h1555, 1'b0, 1'b0, '0);
    plan_beat(200, 7, 1'b1, 1'b0, '0);
    plan_beat(200, 7, 1'b1, 1'b0, '0);
    // With tracking off the stored hot mark is still reported.
    plan_cfg(REG_TRACKING_ENABLE, 8'd0);
    plan_beat(200, 7, 1'b0, 1'b1, hpp_out_t'{13'd200, 1'b1, 1'b0, 1'b0, 13'd0, 14'd1});
    plan_cfg(REG_TRACKING_ENABLE, 8'd1);
    plan_cfg(REG_PROMOTE_THRESHOLD, 8'd255);
    plan_cfg(REG_COOLDOWN_THRESHOLD, 8'd255);
    plan_beat(200, 7, 1'b0, 1'b0, '0);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        wait_drained();
        write_reg(plan_q[i].reg_sel, plan_q[i].reg_val);
      end else begin
        send_beat(plan_q[i].beat, plan_q[i].known, plan_q[i].want);
      end
    end

    slot_pool[0] = 0;
    slot_pool[1] = 8191;
    for (int i = 2; i < POOL_N; i++) slot_pool[i] = $urandom_range(8191);

    run_phase(1'b1, 8'd3, 8'd3, 0, 0, 150, POOL_N, 1, 8, 1'b0);
    run_phase(1'b1, 8'd0, 8'd0, 63, 0, 150, POOL_N, 1, 4, 1'b0);
    run_phase(1'b1, 8'd1, 8'd5, 0, 63, 150, POOL_N, 1, 10, 1'b0);
    run_phase(1'b1, 8'd6, 8'd2, 34, 34, 150, POOL_N, 1, 10, 1'b0);
    run_phase(1'b0, 8'd2, 8'd2, 20, 20, 60, POOL_N, 1, 6, 1'b0);
    // Runs longer than 255 frames saturate both run counters.
    run_phase(1'b1, 8'd255, 8'd255, 0, 0, 300, 2, 256, 270, 1'b0);
    // Receiver holds off while beats keep coming, so the input backs up.
    run_phase(1'b1, 8'd2, 8'd1, 0, 0, 100, POOL_N, 1, 5, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d page beats and %0d results over seven register settings,",
             n_beats, n_results);
    $display("with %0d promotions and %0d reprotects seen.", n_promoted, n_reprotect);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hpp_pkg.sv
sv/hpp_page_store.sv
sv/hpp_update.sv
sv/hot_page_promotion_policy.sv
test/hot_page_promotion_policy_tb.sv
